// ===== hdl/sni_pkg.sv =====
// ----------------------------------------------------------------------------
// sni_pkg
// Shared types, constants and the panel micro-program of the Simpson
// integrator on an uneven grid.
// ----------------------------------------------------------------------------
package sni_pkg;

	localparam int XY_W        = 32;                       // Q16.16 sample width
	localparam int H_W         = XY_W + 1;                 // grid step width
	localparam int NW          = 36;                       // narrow operand width
	localparam int WW          = 144;                      // wide working width
	localparam int ECNT_W      = $clog2(WW);
	localparam int MAX_SAMPLES = 65536;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 3);
	localparam int STEP_W      = 5;

	localparam logic [STEP_W-1:0] STEP_FULL     = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_FULL_DIV = STEP_W'(8);
	localparam logic [STEP_W-1:0] STEP_HALF     = STEP_W'(9);
	localparam logic [STEP_W-1:0] STEP_HALF_DIV = STEP_W'(19);

	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_SHORT = 2'd1,
		STAT_ZERO  = 2'd2,
		STAT_SAT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_WAIT, S_ACC, S_DONE
	} seq_st_t;

	typedef enum logic [2:0] {
		E_IDLE, E_MUL, E_NEGN, E_NEGD, E_DIV, E_QNEG, E_SAT
	} eng_st_t;

	typedef enum logic {OP_MUL, OP_DIV} op_t;
	typedef enum logic [1:0] {A_R0, A_R1, A_NAR} asrc_t;
	typedef enum logic [1:0] {D_R0, D_R1, D_R2} dest_t;
	typedef enum logic [1:0] {M_SET, M_ADD, M_SUB} mode_t;

	typedef enum logic [3:0] {
		N_HH, N_H0, N_H1, N_Y0, N_Y1, N_Y2,
		N_2H0_H1, N_2H1_H0, N_3HH_H0, N_3H1, N_6H0, N_6H1
	} nar_t;

	typedef struct packed {
		op_t   op;
		asrc_t a_src;
		nar_t  na;
		nar_t  nb;
		dest_t dest;
		mode_t mode;
	} uinst_t;

	typedef struct packed {
		logic                 start;
		op_t                  op;
		asrc_t                a_src;
		logic signed [NW-1:0] a_nar;
		logic signed [NW-1:0] b_val;
		dest_t                dest;
		mode_t                mode;
	} eng_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic        qsat;
	} eng_rsp_t;

	function automatic uinst_t mk(op_t op, asrc_t a, nar_t na, nar_t nb,
			dest_t d, mode_t m);
		uinst_t u;
		u.op = op; u.a_src = a; u.na = na; u.nb = nb; u.dest = d; u.mode = m;
		return u;
	endfunction

	// Full panel: num = hh*(hh*hh*y1 + (2h0-h1)h1*y0 + (2h1-h0)h0*y2), den = 6h0*h1.
	// Half panel: num = h0*(c1*y1 + (3hh-h0)h1*y0 - h0*h0*y2), den = 6h1*hh.
	function automatic uinst_t prog(logic [STEP_W-1:0] step);
		uinst_t u;
		case (step)
			5'd0:    u = mk(OP_MUL, A_NAR, N_HH,     N_HH, D_R0, M_SET);
			5'd1:    u = mk(OP_MUL, A_R0,  N_HH,     N_Y1, D_R1, M_SET);
			5'd2:    u = mk(OP_MUL, A_NAR, N_2H0_H1, N_H1, D_R0, M_SET);
			5'd3:    u = mk(OP_MUL, A_R0,  N_HH,     N_Y0, D_R1, M_ADD);
			5'd4:    u = mk(OP_MUL, A_NAR, N_2H1_H0, N_H0, D_R0, M_SET);
			5'd5:    u = mk(OP_MUL, A_R0,  N_HH,     N_Y2, D_R1, M_ADD);
			5'd6:    u = mk(OP_MUL, A_R1,  N_HH,     N_HH, D_R1, M_SET);
			5'd7:    u = mk(OP_MUL, A_NAR, N_6H0,    N_H1, D_R2, M_SET);
			5'd8:    u = mk(OP_DIV, A_R1,  N_HH,     N_HH, D_R1, M_SET);
			5'd9:    u = mk(OP_MUL, A_NAR, N_3H1,    N_HH, D_R0, M_SET);
			5'd10:   u = mk(OP_MUL, A_NAR, N_H0,     N_H0, D_R0, M_ADD);
			5'd11:   u = mk(OP_MUL, A_NAR, N_H0,     N_H1, D_R0, M_ADD);
			5'd12:   u = mk(OP_MUL, A_R0,  N_HH,     N_Y1, D_R1, M_SET);
			5'd13:   u = mk(OP_MUL, A_NAR, N_3HH_H0, N_H1, D_R0, M_SET);
			5'd14:   u = mk(OP_MUL, A_R0,  N_HH,     N_Y0, D_R1, M_ADD);
			5'd15:   u = mk(OP_MUL, A_NAR, N_H0,     N_H0, D_R0, M_SET);
			5'd16:   u = mk(OP_MUL, A_R0,  N_HH,     N_Y2, D_R1, M_SUB);
			5'd17:   u = mk(OP_MUL, A_R1,  N_HH,     N_H0, D_R1, M_SET);
			5'd18:   u = mk(OP_MUL, A_NAR, N_6H1,    N_HH, D_R2, M_SET);
			default: u = mk(OP_DIV, A_R1,  N_HH,     N_HH, D_R1, M_SET);
		endcase
		return u;
	endfunction

	// Narrow operand built from the grid steps and the three sample values.
	function automatic logic signed [NW-1:0] nar_val(nar_t sel,
			logic signed [H_W-1:0] h0, logic signed [H_W-1:0] h1,
			logic signed [H_W-1:0] hh, logic signed [XY_W-1:0] y0,
			logic signed [XY_W-1:0] y1, logic signed [XY_W-1:0] y2);
		logic signed [NW-1:0] a0, a1, ah, r;
		a0 = NW'(h0);
		a1 = NW'(h1);
		ah = NW'(hh);
		case (sel)
			N_HH:     r = ah;
			N_H0:     r = a0;
			N_H1:     r = a1;
			N_Y0:     r = NW'(y0);
			N_Y1:     r = NW'(y1);
			N_Y2:     r = NW'(y2);
			N_2H0_H1: r = (a0 <<< 1) - a1;
			N_2H1_H0: r = (a1 <<< 1) - a0;
			N_3HH_H0: r = (ah <<< 1) + ah - a0;
			N_3H1:    r = (a1 <<< 1) + a1;
			N_6H0:    r = (a0 <<< 2) + (a0 <<< 1);
			N_6H1:    r = (a1 <<< 2) + (a1 <<< 1);
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/sni_engine.sv =====
// ----------------------------------------------------------------------------
// sni_engine
// Shared wide arithmetic unit: shift-add multiply and restoring divide
// around one 144-bit adder, with three working registers.
// ----------------------------------------------------------------------------
module sni_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  sni_pkg::eng_cmd_t  cmd,
	output sni_pkg::eng_rsp_t  rsp
);

	localparam int WW = sni_pkg::WW;
	localparam int NW = sni_pkg::NW;
	localparam int EW = sni_pkg::ECNT_W;

	sni_pkg::eng_st_t est_q, est_nxt;
	logic [WW-1:0]    r0_q, r1_q, r2_q, mcand_q, acc_q;
	logic [NW-1:0]    mplier_q;
	logic [EW-1:0]    cnt_q;
	logic             neg_q;
	sni_pkg::dest_t   dest_q;

	logic [WW-1:0] add_a, add_b, add_sum, rem_sh, a_start, dest_val, mul_acc;
	logic          add_inv, mul_last, div_last, ge, fits;

	assign mul_last = (cnt_q == EW'(NW - 1));
	assign div_last = (cnt_q == EW'(WW - 1));
	assign rem_sh   = {acc_q[WW-2:0], mcand_q[WW-1]};
	assign ge       = ~add_sum[WW-1];
	assign mul_acc  = mplier_q[0] ? add_sum : acc_q;

	// shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_inv = 1'b0;
		case (est_q)
			sni_pkg::E_MUL: begin
				add_a   = acc_q;
				add_b   = mcand_q;
				add_inv = neg_q ^ mul_last;
			end
			sni_pkg::E_NEGN: begin
				add_b   = r1_q;
				add_inv = 1'b1;
			end
			sni_pkg::E_NEGD: begin
				add_b   = r2_q;
				add_inv = 1'b1;
			end
			sni_pkg::E_DIV: begin
				add_a   = rem_sh;
				add_b   = r2_q;
				add_inv = 1'b1;
			end
			sni_pkg::E_QNEG: begin
				add_b   = mcand_q;
				add_inv = 1'b1;
			end
			default: begin
				add_inv = 1'b0;
			end
		endcase
	end
	assign add_sum = add_a + (add_b ^ {WW{add_inv}}) + WW'(add_inv);

	always_comb begin
		case (cmd.a_src)
			sni_pkg::A_R0: a_start = r0_q;
			sni_pkg::A_R1: a_start = r1_q;
			default:       a_start = WW'(cmd.a_nar);
		endcase
		case (cmd.dest)
			sni_pkg::D_R0: dest_val = r0_q;
			sni_pkg::D_R1: dest_val = r1_q;
			default:       dest_val = r2_q;
		endcase
	end

	always_comb begin
		est_nxt = est_q;
		case (est_q)
			sni_pkg::E_IDLE: begin
				if (cmd.start)
					est_nxt = (cmd.op == sni_pkg::OP_MUL) ? sni_pkg::E_MUL : sni_pkg::E_NEGN;
			end
			sni_pkg::E_MUL:  if (mul_last) est_nxt = sni_pkg::E_IDLE;
			sni_pkg::E_NEGN: est_nxt = sni_pkg::E_NEGD;
			sni_pkg::E_NEGD: est_nxt = sni_pkg::E_DIV;
			sni_pkg::E_DIV:  if (div_last) est_nxt = sni_pkg::E_QNEG;
			sni_pkg::E_QNEG: est_nxt = sni_pkg::E_SAT;
			sni_pkg::E_SAT:  est_nxt = sni_pkg::E_IDLE;
			default:         est_nxt = sni_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= sni_pkg::E_IDLE;
		end else begin
			est_q <= est_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (est_q)
			sni_pkg::E_IDLE: begin
				if (cmd.start) begin
					cnt_q  <= '0;
					dest_q <= cmd.dest;
					if (cmd.op == sni_pkg::OP_MUL) begin
						mcand_q  <= a_start;
						mplier_q <= cmd.b_val;
						acc_q    <= (cmd.mode == sni_pkg::M_SET) ? '0 : dest_val;
						neg_q    <= (cmd.mode == sni_pkg::M_SUB);
					end else begin
						neg_q <= r1_q[WW-1] ^ r2_q[WW-1];
					end
				end
			end
			sni_pkg::E_MUL: begin
				acc_q    <= mul_acc;
				mcand_q  <= {mcand_q[WW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[NW-1:1]};
				cnt_q    <= cnt_q + EW'(1);
				if (mul_last) begin
					case (dest_q)
						sni_pkg::D_R0: r0_q <= mul_acc;
						sni_pkg::D_R1: r1_q <= mul_acc;
						default:       r2_q <= mul_acc;
					endcase
				end
			end
			sni_pkg::E_NEGN: begin
				if (r1_q[WW-1]) r1_q <= add_sum;
			end
			sni_pkg::E_NEGD: begin
				if (r2_q[WW-1]) r2_q <= add_sum;
				mcand_q <= r1_q;
				acc_q   <= '0;
				cnt_q   <= '0;
			end
			sni_pkg::E_DIV: begin
				acc_q   <= ge ? add_sum : rem_sh;
				mcand_q <= {mcand_q[WW-2:0], ge};
				cnt_q   <= cnt_q + EW'(1);
			end
			sni_pkg::E_QNEG: begin
				if (neg_q) mcand_q <= add_sum;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign fits = (&mcand_q[WW-1:63]) | ~(|mcand_q[WW-1:63]);

	always_comb begin
		rsp.done = ((est_q == sni_pkg::E_MUL) && mul_last) || (est_q == sni_pkg::E_SAT);
		rsp.qsat = ~fits;
		if (fits)
			rsp.quot = mcand_q[63:0];
		else
			rsp.quot = mcand_q[WW-1] ? sni_pkg::Q_MIN : sni_pkg::Q_MAX;
	end

endmodule

// ===== hdl/simpson_nonuniform_integrator_top.sv =====
// ----------------------------------------------------------------------------
// simpson_nonuniform_integrator_top
// Composite Simpson integral of (x, y) samples on an uneven grid.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one item per sample, sample_x and
//    sample_y in signed Q16.16, last set on the final sample of a curve.
//  - Output channel (out_valid/out_ready): one item per curve, after the
//    sample with last; integral in signed Q32.32, status 0 ok, 1 short
//    curve, 2 zero-width interval, 3 saturated.
//  - One sample at a time: in_ready is high only while the sequencer idles.
//    A sample that closes no panel goes straight to done. A sample that closes a
//    full panel runs eight multiplies (each an issue and 36 shift-add
//    steps) and one restoring divide (issue, two sign fixes, 144 steps,
//    quotient sign, clamp) on the shared 144-bit adder, then accumulate and
//    done. The third sample of a curve also runs the half panel.
//  - The result waits in an output register; the next curve keeps flowing
//    in until its own result is due, then the block stalls until the
//    previous result is taken.
//  - Reset clears the sample history, both sums, the count and all flags.
// ----------------------------------------------------------------------------
module simpson_nonuniform_integrator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [sni_pkg::XY_W-1:0] sample_x,
	input  logic signed [sni_pkg::XY_W-1:0] sample_y,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [63:0]              integral,
	output logic [1:0]                      status
);

	localparam int XY_W   = sni_pkg::XY_W;
	localparam int H_W    = sni_pkg::H_W;
	localparam int CNT_W  = sni_pkg::CNT_W;
	localparam int STEP_W = sni_pkg::STEP_W;
	localparam int MAXS   = sni_pkg::MAX_SAMPLES;

	sni_pkg::seq_st_t st_q, st_nxt;

	// stream state
	logic signed [XY_W-1:0] older_x_q, newer_x_q, older_y_q, newer_y_q;
	logic [63:0]            sum_even_q, sum_odd_q;
	logic                   sat_even_q, sat_odd_q, err_q, last_q;
	logic [CNT_W-1:0]       cnt_q;

	// panel snapshot and sequencer
	logic signed [H_W-1:0]  h0_q, h1_q, hh_q;
	logic signed [XY_W-1:0] y0_q, y1_q, y2_q;
	logic [STEP_W-1:0]      mstep_q;
	logic [63:0]            q_q;
	logic                   qsat_q;

	logic                   out_valid_q;
	logic [63:0]            integral_q;
	sni_pkg::status_t       status_q;

	sni_pkg::eng_cmd_t cmd;
	sni_pkg::eng_rsp_t rsp;
	sni_pkg::uinst_t   ui;

	logic                  accept, zero_adj, n3_in, err_mid, panel, err_nxt;
	logic [CNT_W-1:0]      cnt_nxt;
	logic signed [H_W-1:0] h0_in, h1_in, hh_in;

	logic        tgt_odd, acc_ovf, acc_sat, load_out, clear_stream;
	logic [63:0] acc_base, acc_res;
	logic [64:0] acc_s;

	sni_pkg::status_t res_status;
	logic [63:0]      res_integral;

	assign accept = in_valid && in_ready;
	assign ui     = sni_pkg::prog(mstep_q);

	// advance the sample count; past the cap it toggles and keeps its parity
	assign cnt_nxt = (cnt_q >= CNT_W'(MAXS + 2)) ? CNT_W'(MAXS + 1) : cnt_q + CNT_W'(1);
	assign h0_in   = H_W'(newer_x_q) - H_W'(older_x_q);
	assign h1_in   = H_W'(sample_x) - H_W'(newer_x_q);
	assign hh_in   = H_W'(sample_x) - H_W'(older_x_q);
	assign n3_in   = (cnt_nxt == CNT_W'(3));
	assign zero_adj = (cnt_nxt >= CNT_W'(2)) && (sample_x == newer_x_q);
	assign err_mid = err_q | zero_adj;
	assign panel   = (cnt_nxt >= CNT_W'(3)) && !err_mid && !(n3_in && (hh_in == '0));
	assign err_nxt = err_mid | ((cnt_nxt >= CNT_W'(3)) && n3_in && (hh_in == '0));

	// saturating accumulate of the panel into the alignment it belongs to
	assign tgt_odd  = (mstep_q == sni_pkg::STEP_HALF_DIV) || !cnt_q[0];
	assign acc_base = tgt_odd ? sum_odd_q : sum_even_q;
	assign acc_s    = {acc_base[63], acc_base} + {q_q[63], q_q};
	assign acc_ovf  = acc_s[64] ^ acc_s[63];
	assign acc_res  = acc_ovf ? (acc_s[64] ? sni_pkg::Q_MIN : sni_pkg::Q_MAX) : acc_s[63:0];
	assign acc_sat  = acc_ovf | qsat_q;

	// pick the result by priority: short curve, zero width, then parity
	always_comb begin
		if (cnt_q < CNT_W'(3)) begin
			res_integral = '0;
			res_status   = sni_pkg::STAT_SHORT;
		end else if (err_q) begin
			res_integral = '0;
			res_status   = sni_pkg::STAT_ZERO;
		end else if (cnt_q[0]) begin
			res_integral = sum_even_q;
			res_status   = sat_even_q ? sni_pkg::STAT_SAT : sni_pkg::STAT_OK;
		end else begin
			res_integral = sum_odd_q;
			res_status   = sat_odd_q ? sni_pkg::STAT_SAT : sni_pkg::STAT_OK;
		end
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			sni_pkg::S_IDLE: begin
				if (accept) st_nxt = panel ? sni_pkg::S_ISSUE : sni_pkg::S_DONE;
			end
			sni_pkg::S_ISSUE: st_nxt = sni_pkg::S_WAIT;
			sni_pkg::S_WAIT: begin
				if (rsp.done)
					st_nxt = (ui.op == sni_pkg::OP_DIV) ? sni_pkg::S_ACC : sni_pkg::S_ISSUE;
			end
			sni_pkg::S_ACC: begin
				if ((mstep_q == sni_pkg::STEP_FULL_DIV) && (cnt_q == CNT_W'(3)))
					st_nxt = sni_pkg::S_ISSUE;
				else
					st_nxt = sni_pkg::S_DONE;
			end
			sni_pkg::S_DONE: begin
				if (!last_q || !out_valid_q || out_ready) st_nxt = sni_pkg::S_IDLE;
			end
			default: st_nxt = sni_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready     = (st_q == sni_pkg::S_IDLE);
		load_out     = (st_q == sni_pkg::S_DONE) && last_q && (!out_valid_q || out_ready);
		clear_stream = load_out;
		cmd.start    = (st_q == sni_pkg::S_ISSUE);
		cmd.op       = ui.op;
		cmd.a_src    = ui.a_src;
		cmd.a_nar    = sni_pkg::nar_val(ui.na, h0_q, h1_q, hh_q, y0_q, y1_q, y2_q);
		cmd.b_val    = sni_pkg::nar_val(ui.nb, h0_q, h1_q, hh_q, y0_q, y1_q, y2_q);
		cmd.dest     = ui.dest;
		cmd.mode     = ui.mode;
	end

	sni_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= sni_pkg::S_IDLE;
			older_x_q   <= '0;
			newer_x_q   <= '0;
			older_y_q   <= '0;
			newer_y_q   <= '0;
			sum_even_q  <= '0;
			sum_odd_q   <= '0;
			sat_even_q  <= 1'b0;
			sat_odd_q   <= 1'b0;
			err_q       <= 1'b0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (accept) begin
				// shift the history now; the panel works from its own snapshot
				older_x_q <= newer_x_q;
				older_y_q <= newer_y_q;
				newer_x_q <= sample_x;
				newer_y_q <= sample_y;
				cnt_q     <= cnt_nxt;
				err_q     <= err_nxt;
				last_q    <= last;
				mstep_q   <= sni_pkg::STEP_FULL;
			end

			if ((st_q == sni_pkg::S_WAIT) && rsp.done && (ui.op == sni_pkg::OP_MUL))
				mstep_q <= mstep_q + STEP_W'(1);

			if (st_q == sni_pkg::S_ACC) begin
				if (tgt_odd) begin
					sum_odd_q <= acc_res;
					sat_odd_q <= sat_odd_q | acc_sat;
				end else begin
					sum_even_q <= acc_res;
					sat_even_q <= sat_even_q | acc_sat;
				end
				if (mstep_q == sni_pkg::STEP_FULL_DIV)
					mstep_q <= sni_pkg::STEP_HALF;
			end

			if (clear_stream) begin
				older_x_q  <= '0;
				newer_x_q  <= '0;
				older_y_q  <= '0;
				newer_y_q  <= '0;
				sum_even_q <= '0;
				sum_odd_q  <= '0;
				sat_even_q <= 1'b0;
				sat_odd_q  <= 1'b0;
				err_q      <= 1'b0;
				cnt_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h0_q <= h0_in;
			h1_q <= h1_in;
			hh_q <= hh_in;
			y0_q <= older_y_q;
			y1_q <= newer_y_q;
			y2_q <= sample_y;
		end
		if ((st_q == sni_pkg::S_WAIT) && rsp.done) begin
			q_q    <= rsp.quot;
			qsat_q <= rsp.qsat;
		end
		if (load_out) begin
			integral_q <= res_integral;
			status_q   <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign integral  = integral_q;
	assign status    = status_q;

endmodule

// ===== hdl/sni_checker.sv =====
// ----------------------------------------------------------------------------
// sni_checker
// Port-level assertions for the Simpson integrator, bound to the top level.
// ----------------------------------------------------------------------------
module sni_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] integral,
	input logic [1:0]  status
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(integral) && $stable(status))
		else $error("result changed while stalled");

	// error results carry a zero integral
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sni_pkg::STAT_SHORT || status == sni_pkg::STAT_ZERO)
		|-> integral == 64'd0)
		else $error("error result with nonzero integral");

	// one sample at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted item");

endmodule

bind simpson_nonuniform_integrator_top sni_checker u_sni_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.integral  (integral),
	.status    (status)
);

// ===== tb/simpson_nonuniform_integrator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simpson_nonuniform_integrator_top_test
// Streams curves of (x, y) samples into the Simpson integrator and checks
// each integral and status against an exact wide-integer model of both
// panel alignments, under random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
module simpson_nonuniform_integrator_top_test;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [63:0] integral;
		sni_pkg::status_t   status;
	} curve_result_t;

	// Exact model of the integrator: keeps the last two samples, both running
	// sums and the error state, and queues one result per closed curve.
	class simpson_scoreboard;
		logic signed [63:0] px0, px1, py0, py1;
		logic signed [63:0] sum_even, sum_odd;
		bit                 sat_even, sat_odd;
		int                 cnt;
		bit                 zero_err;
		curve_result_t      pending_q[$];
		int                 errors;
		int                 results;
		int                 stat_seen[4];

		function void clear();
			px0 = 0; px1 = 0; py0 = 0; py1 = 0;
			sum_even = 0; sum_odd = 0;
			sat_even = 0; sat_odd = 0;
			cnt = 0; zero_err = 0;
		endfunction

		function logic signed [63:0] clip(wide_t v, inout bit s);
			wide_t hi, lo;
			hi = wide_t'(sni_pkg::Q_MAX);
			lo = -hi - 1;
			if (v > hi) begin
				s = 1;
				return sni_pkg::Q_MAX;
			end
			if (v < lo) begin
				s = 1;
				return sni_pkg::Q_MIN;
			end
			return v[63:0];
		endfunction

		function void note(logic signed [31:0] x, logic signed [31:0] y, logic lst);
			wide_t h0, h1, hh, y0, y1, y2, num, den, c1;
			logic signed [63:0] p;
			bit s;
			curve_result_t r;
			if (cnt >= sni_pkg::MAX_SAMPLES + 2)
				cnt = sni_pkg::MAX_SAMPLES + 1;
			else
				cnt++;
			if (cnt >= 2 && 64'(x) == px1)
				zero_err = 1;
			if (cnt >= 3 && !zero_err) begin
				h0 = wide_t'(px1) - wide_t'(px0);
				h1 = wide_t'(x) - wide_t'(px1);
				hh = wide_t'(x) - wide_t'(px0);
				y0 = wide_t'(py0);
				y1 = wide_t'(py1);
				y2 = wide_t'(y);
				num = ((2 * h0 - h1) * h1 * y0 + hh * hh * y1 + (2 * h1 - h0) * h0 * y2) * hh;
				den = 6 * h0 * h1;
				if (cnt == 3 && hh == 0) begin
					zero_err = 1;
				end else if (cnt == 3) begin
					s = 0;
					p = clip(num / den, s);
					sum_even = clip(wide_t'(sum_even) + wide_t'(p), s);
					sat_even |= s;
					// Half panel over the first interval, fitted through all three samples.
					c1 = 3 * h1 * hh + h0 * h0 + h0 * h1;
					num = ((3 * hh - h0) * h1 * y0 + c1 * y1 - h0 * h0 * y2) * h0;
					den = 6 * h1 * hh;
					s = 0;
					p = clip(num / den, s);
					sum_odd = clip(wide_t'(sum_odd) + wide_t'(p), s);
					sat_odd |= s;
				end else begin
					s = 0;
					p = clip(num / den, s);
					if (cnt % 2 == 1) begin
						sum_even = clip(wide_t'(sum_even) + wide_t'(p), s);
						sat_even |= s;
					end else begin
						sum_odd = clip(wide_t'(sum_odd) + wide_t'(p), s);
						sat_odd |= s;
					end
				end
			end
			px0 = px1; py0 = py1;
			px1 = x; py1 = y;
			if (!lst)
				return;
			if (cnt < 3) begin
				r.integral = 0; r.status = sni_pkg::STAT_SHORT;
			end else if (zero_err) begin
				r.integral = 0; r.status = sni_pkg::STAT_ZERO;
			end else if (cnt % 2 == 1) begin
				r.integral = sum_even;
				r.status = sat_even ? sni_pkg::STAT_SAT : sni_pkg::STAT_OK;
			end else begin
				r.integral = sum_odd;
				r.status = sat_odd ? sni_pkg::STAT_SAT : sni_pkg::STAT_OK;
			end
			pending_q.push_back(r);
			clear();
		endfunction

		function void check(logic signed [63:0] integral, logic [1:0] status);
			curve_result_t r;
			results++;
			stat_seen[status]++;
			if (pending_q.size() == 0) begin
				$error("unexpected result: integral %0d status %0d", integral, status);
				errors++;
				return;
			end
			r = pending_q.pop_front();
			if (integral !== r.integral) begin
				$error("integral: expected %0d, actual %0d", r.integral, integral);
				errors++;
			end
			if (status !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, status);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [31:0] sample_x = 0;
	logic signed [31:0] sample_y = 0;
	logic               last = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [63:0] integral;
	logic [1:0]         status;

	simpson_scoreboard sb = new();

	// Curve under construction.
	logic signed [31:0] cx[$];
	logic signed [31:0] cy[$];
	int                 items_sent = 0;
	int                 curves_sent = 0;
	int                 burst_left = 0;
	bit                 hold_done = 0;
	bit                 drain_done = 0;

	simpson_nonuniform_integrator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_x (sample_x),
		.sample_y (sample_y),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.integral (integral),
		.status   (status)
	);

	always #4 clk = ~clk;

	// Watch both handshakes at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note(sample_x, sample_y, last);
		if (out_valid && out_ready)
			sb.check(integral, status);
	end

	// Receiver: random stall patterns, with one long hold-off to back up the block.
	initial begin
		int mode;
		int seg;
		@(posedge arst_n);
		forever begin
			if (!hold_done && items_sent > 400) begin
				hold_done = 1;
				@(negedge clk);
				out_ready <= 0;
				repeat (40000) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			seg = $urandom_range(20, 400);
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Offer one sample and hold it until taken; open a gap between bursts.
	task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y, logic l);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		in_valid <= 1;
		sample_x <= x;
		sample_y <= y;
		last     <= l;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_curve();
		for (int i = 0; i < cx.size(); i++)
			send_sample(cx[i], cy[i], i == cx.size() - 1);
		curves_sent++;
	endtask

	// Build an increasing grid with random steps up to step_max and y within ymag.
	task automatic build_curve(int len, int step_max, int ymag);
		logic signed [31:0] x;
		cx.delete();
		cy.delete();
		x = $urandom_range(0, 2 * step_max) - step_max;
		for (int i = 0; i < len; i++) begin
			cx.push_back(x);
			cy.push_back($urandom_range(0, 2 * ymag) - ymag);
			x = x + $urandom_range(1, step_max);
		end
	endtask

	task automatic noise_curve(int len);
		cx.delete();
		cy.delete();
		for (int i = 0; i < len; i++) begin
			cx.push_back($urandom);
			cy.push_back($urandom);
		end
	endtask

	initial begin
		int kind;
		int len;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Short curves: one and two samples.
		build_curve(1, 1000, 1000); send_curve();
		build_curve(2, 1000, 1000); send_curve();
		// Odd and even counts on a gentle grid.
		build_curve(3, 65536, 65536 * 4); send_curve();
		build_curve(4, 65536, 65536 * 4); send_curve();
		// Zero-width step in the middle.
		build_curve(4, 5000, 100000); cx[2] = cx[1]; send_curve();
		// First and third abscissas equal.
		cx = '{32'sd1000, 32'sd5000, 32'sd1000};
		cy = '{32'sd7, -32'sd9, 32'sd11};
		send_curve();
		// Extreme fields: widest grid and largest values, saturating.
		cx = '{32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF};
		cy = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_curve();
		cx = '{32'h8000_0000, 32'hC000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
		cy = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_curve();
		// Tiny first step next to a huge one.
		cx = '{32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF};
		cy = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
		send_curve();

		while (items_sent < 1450) begin
			if (!drain_done && items_sent > 800) begin
				// Drain: hold the input until every result has been taken.
				drain_done = 1;
				in_valid <= 0;
				burst_left = 0;
				while (sb.pending_q.size() != 0) @(negedge clk);
			end
			kind = $urandom_range(0, 19);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(3, 9);
			if (kind < 10)
				build_curve(len, 1 << $urandom_range(1, 24), 1 << $urandom_range(4, 30));
			else if (kind < 12)
				build_curve($urandom_range(1, 2), 10000, 1 << 20);
			else if (kind < 14) begin
				build_curve(len, 1 << 20, 1 << 24);
				if (len > 1)
					cx[$urandom_range(1, len - 1)] = cx[$urandom_range(0, len - 1)];
			end else if (kind < 16)
				build_curve(len, 1 << 28, 32'h7FFF_FFFF);
			else
				noise_curve(len);
			send_curve();
		end
		in_valid <= 0;

		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
		$display("Ran %0d samples in %0d curves; %0d results checked.",
			items_sent, curves_sent, sb.results);
		$display("Status counts: ok %0d, short %0d, zero width %0d, saturated %0d.",
			sb.stat_seen[0], sb.stat_seen[1], sb.stat_seen[2], sb.stat_seen[3]);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		sb.clear();
		#100ms;
		$display("timeout after %0d samples", items_sent);
		$display("== FAIL ==");
		$finish;
	end

endmodule
